// ===== sv/assert_macros.svh =====
// Assertion helpers for the code table builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/chtb_pkg.sv =====
// ----------------------------------------------------------------------------
// chtb_pkg
// Shared types and codes of the canonical Huffman code table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package chtb_pkg;

  localparam int HDR_W  = 9;
  localparam int CNT_W  = 10;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef logic [HDR_W-1:0]  hdr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic  valid;
    len_t  len;
    code_t code;
  } entry_t;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_SYMBOLS,
    PH_LENGTHS,
    PH_READY
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_RUN,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

// ===== sv/chtb_ram.sv =====
// ----------------------------------------------------------------------------
// chtb_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module chtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/canonical_huffman_table_builder_unit.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table_builder_unit
// Rebuilds a canonical Huffman code table from header words and answers
// per-symbol code queries.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): opcode_i selects a header word
// (header_word_i) or a query (query_symbol_i). Output channel
// (out_valid_o/out_ready_i) carries one result per query transfer; header
// words produce none.
// Per item: a symbol word is taken in ST_IDLE and needs no further state; a query
// passes through ST_QUERY to the output register (one entry memory read); a
// per-length count word passes through ST_RUN and ST_DRAIN, with one symbol-order
// memory read and one entry memory write per assigned symbol, pipelined one per cycle.
// Reset and each symbol count word start a clearing pass over all 2^SYMBOL_BITS
// entries of the entry memory (512 at the default) with in_ready_o low.
// Output is one register: header words keep flowing while a result waits, and
// a query then holds in place until the result register is free, so a stalled
// receiver stalls the input at the next query.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_table_builder_unit #(
  parameter int SYMBOL_BITS  = 9,
  parameter int MAX_CODE_LEN = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [8:0]  header_word_i,
  input  wire logic [8:0]  query_symbol_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [15:0]      code_value_o,
  output logic [4:0]       code_length_o,
  output logic             table_ready_o,
  output logic             error_flag_o
);

  localparam int Depth = 1 << SYMBOL_BITS;
  localparam int CodeW = MAX_CODE_LEN + 1;
  localparam int LenW  = $clog2(MAX_CODE_LEN + 2);
  localparam int MaskW = (CodeW > chtb_pkg::CODE_W) ? CodeW : chtb_pkg::CODE_W;
  localparam int EntW  = $bits(chtb_pkg::entry_t);

  typedef logic [SYMBOL_BITS-1:0] sym_t;

  chtb_pkg::state_e state_q, state_d;
  chtb_pkg::phase_e phase_q, phase_d;

  chtb_pkg::cnt_t total_q, total_d;
  chtb_pkg::cnt_t recv_q, recv_d;
  chtb_pkg::cnt_t covered_q, covered_d;
  chtb_pkg::cnt_t assigned_q, assigned_d;
  chtb_pkg::cnt_t left_q, left_d;
  chtb_pkg::hdr_t count_q, count_d;
  logic [CodeW-1:0] next_code_q, next_code_d;
  logic [LenW-1:0]  cur_len_q, cur_len_d;
  logic             err_q, err_d;
  sym_t             clr_addr_q, clr_addr_d;

  logic             pipe_v_q, pipe_v_d;
  chtb_pkg::code_t  pipe_code_q, pipe_code_d;
  chtb_pkg::len_t   pipe_len_q, pipe_len_d;

  logic             out_valid_q, out_valid_d;
  chtb_pkg::entry_t out_ent_q, out_ent_d;
  logic             out_rdy_q, out_rdy_d;
  logic             out_err_q, out_err_d;

  logic             ord_we, ord_re;
  sym_t             ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic             ent_we, ent_re;
  sym_t             ent_waddr, ent_raddr;
  chtb_pkg::entry_t ent_wdata, ent_rdata;

  chtb_pkg::cnt_t   remaining, cnt_word, n_assign;
  logic             over, too_long;
  logic [MaskW-1:0] len_mask, code_ext;
  logic [chtb_pkg::CNT_W:0] cov_sum;

  chtb_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (Depth)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  chtb_ram #(
    .WIDTH (EntW),
    .DEPTH (Depth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      len_mask[i] = (i < int'(cur_len_q));
    end
    code_ext = MaskW'(next_code_q) & len_mask;
  end

  assign cnt_word  = chtb_pkg::cnt_t'(header_word_i);
  assign remaining = total_q - assigned_q;
  assign over      = cnt_word > remaining;
  assign n_assign  = over ? remaining : cnt_word;
  assign too_long  = (n_assign != '0) && (cur_len_q > LenW'(MAX_CODE_LEN));
  assign cov_sum   = {1'b0, covered_q} + (chtb_pkg::CNT_W + 1)'(count_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    total_d     = total_q;
    recv_d      = recv_q;
    covered_d   = covered_q;
    assigned_d  = assigned_q;
    left_d      = left_q;
    count_d     = count_q;
    next_code_d = next_code_q;
    cur_len_d   = cur_len_q;
    err_d       = err_q;
    clr_addr_d  = clr_addr_q;
    pipe_v_d    = 1'b0;
    pipe_code_d = pipe_code_q;
    pipe_len_d  = pipe_len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ent_d   = out_ent_q;
    out_rdy_d   = out_rdy_q;
    out_err_d   = out_err_q;

    in_ready_o  = 1'b0;
    ord_we      = 1'b0;
    ord_waddr   = sym_t'(recv_q);
    ord_wdata   = sym_t'(header_word_i);
    ord_re      = 1'b0;
    ord_raddr   = sym_t'(assigned_q);
    ent_we      = 1'b0;
    ent_waddr   = clr_addr_q;
    ent_wdata   = '0;
    ent_re      = 1'b0;
    ent_raddr   = sym_t'(query_symbol_i);

    if (pipe_v_q) begin
      ent_we         = 1'b1;
      ent_waddr      = ord_rdata;
      ent_wdata.valid = 1'b1;
      ent_wdata.len  = pipe_len_q;
      ent_wdata.code = pipe_code_q;
    end

    case (state_q)
      chtb_pkg::ST_CLEAR: begin
        ent_we     = 1'b1;
        ent_waddr  = clr_addr_q;
        ent_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = chtb_pkg::ST_IDLE;
        end
      end
      chtb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == chtb_pkg::OP_QUERY) begin
            ent_re  = 1'b1;
            state_d = chtb_pkg::ST_QUERY;
          end else begin
            case (phase_q)
              chtb_pkg::PH_SYMBOLS: begin
                ord_we = 1'b1;
                recv_d = recv_q + 1'b1;
                if (recv_d >= total_q) begin
                  phase_d = chtb_pkg::PH_LENGTHS;
                end
              end
              chtb_pkg::PH_LENGTHS: begin
                count_d = header_word_i;
                if (over) begin
                  err_d = 1'b1;
                end
                if (too_long) begin
                  err_d      = 1'b1;
                  assigned_d = assigned_q + n_assign;
                  left_d     = '0;
                end else begin
                  left_d = n_assign;
                end
                state_d = chtb_pkg::ST_RUN;
              end
              default: begin
                total_d     = cnt_word;
                recv_d      = '0;
                covered_d   = '0;
                assigned_d  = '0;
                next_code_d = '0;
                cur_len_d   = LenW'(1);
                phase_d     = (cnt_word == '0) ? chtb_pkg::PH_READY : chtb_pkg::PH_SYMBOLS;
                clr_addr_d  = '0;
                state_d     = chtb_pkg::ST_CLEAR;
              end
            endcase
          end
        end
      end
      chtb_pkg::ST_QUERY: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ent_d   = ent_rdata;
          out_rdy_d   = (phase_q == chtb_pkg::PH_READY);
          out_err_d   = err_q;
          state_d     = chtb_pkg::ST_IDLE;
        end
      end
      chtb_pkg::ST_RUN: begin
        if (left_q != '0) begin
          ord_re      = 1'b1;
          pipe_v_d    = 1'b1;
          pipe_code_d = code_ext[chtb_pkg::CODE_W-1:0];
          pipe_len_d  = chtb_pkg::len_t'(cur_len_q);
          next_code_d = next_code_q + 1'b1;
          assigned_d  = assigned_q + 1'b1;
          left_d      = left_q - 1'b1;
        end else begin
          state_d = chtb_pkg::ST_DRAIN;
        end
      end
      chtb_pkg::ST_DRAIN: begin
        next_code_d = {next_code_q[CodeW-2:0], 1'b0};
        if (cur_len_q <= LenW'(MAX_CODE_LEN)) begin
          cur_len_d = cur_len_q + 1'b1;
        end
        covered_d = cov_sum[chtb_pkg::CNT_W] ? chtb_pkg::CNT_SAT
                                             : cov_sum[chtb_pkg::CNT_W-1:0];
        if (covered_d >= total_q) begin
          phase_d = chtb_pkg::PH_READY;
        end
        state_d = chtb_pkg::ST_IDLE;
      end
      default: begin
        state_d = chtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chtb_pkg::ST_CLEAR;
      phase_q     <= chtb_pkg::PH_COUNT;
      total_q     <= '0;
      recv_q      <= '0;
      covered_q   <= '0;
      assigned_q  <= '0;
      left_q      <= '0;
      next_code_q <= '0;
      cur_len_q   <= LenW'(1);
      err_q       <= 1'b0;
      clr_addr_q  <= '0;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      total_q     <= total_d;
      recv_q      <= recv_d;
      covered_q   <= covered_d;
      assigned_q  <= assigned_d;
      left_q      <= left_d;
      next_code_q <= next_code_d;
      cur_len_q   <= cur_len_d;
      err_q       <= err_d;
      clr_addr_q  <= clr_addr_d;
      pipe_v_q    <= pipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    pipe_code_q <= pipe_code_d;
    pipe_len_q  <= pipe_len_d;
    out_ent_q   <= out_ent_d;
    out_rdy_q   <= out_rdy_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_ent_q.valid;
  assign code_value_o  = out_ent_q.code;
  assign code_length_o = out_ent_q.len;
  assign table_ready_o = out_rdy_q;
  assign error_flag_o  = out_err_q;

  `include "assert_macros.svh"

  `CHK_IMPL(a_assigned_le_total, 1'b1, assigned_q <= total_q, "assigned past symbol total")
  `CHK_IMPL(a_pipe_in_run, pipe_v_q,
            state_q == chtb_pkg::ST_RUN || state_q == chtb_pkg::ST_DRAIN,
            "entry write outside code assignment")
  `CHK_IMPL(a_no_write_at_accept, in_ready_o, !pipe_v_q, "transfer with entry write pending")
  `CHK_IMPL(a_total_nonzero,
            phase_q == chtb_pkg::PH_SYMBOLS || phase_q == chtb_pkg::PH_LENGTHS,
            total_q != '0, "empty table still building")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the canonical Huffman code table builder with tables streamed as
// header words and per-symbol code queries. A tracker keeps its own copy of
// the table state, works out the answer for every accepted query and matches
// it against the results coming out, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int MAX_LEN     = 16;
  localparam int STORE_DEPTH = 1 << chtb_pkg::HDR_W;

  typedef struct packed {
    logic            found;
    chtb_pkg::code_t code;
    chtb_pkg::len_t  len;
    logic            ready;
    logic            err;
  } answer_t;

  typedef enum {
    TBL_KRAFT,
    TBL_LOOSE,
    TBL_OVERRUN,
    TBL_DEEP
  } shape_e;

  class code_table_tracker;
    chtb_pkg::phase_e tbl_phase;
    chtb_pkg::cnt_t   sym_total;
    chtb_pkg::cnt_t   sym_seen;
    chtb_pkg::cnt_t   next_idx;
    chtb_pkg::cnt_t   covered;
    logic [MAX_LEN:0] run_code;
    chtb_pkg::len_t   cur_len;
    logic             err_sticky;
    chtb_pkg::hdr_t   order_mem [STORE_DEPTH];
    chtb_pkg::code_t  code_mem [STORE_DEPTH];
    chtb_pkg::len_t   len_mem [STORE_DEPTH];
    bit               mark_mem [STORE_DEPTH];
    answer_t          answers_due [$];
    int               mismatch_count;

    function new();
      tbl_phase      = chtb_pkg::PH_COUNT;
      sym_total      = '0;
      sym_seen       = '0;
      next_idx       = '0;
      covered        = '0;
      run_code       = '0;
      cur_len        = chtb_pkg::len_t'(1);
      err_sticky     = 1'b0;
      mismatch_count = 0;
      foreach (mark_mem[i]) mark_mem[i] = 1'b0;
    endfunction

    function void open_table(chtb_pkg::hdr_t count);
      sym_total = chtb_pkg::cnt_t'(count);
      sym_seen  = '0;
      next_idx  = '0;
      covered   = '0;
      run_code  = '0;
      cur_len   = chtb_pkg::len_t'(1);
      foreach (mark_mem[i]) mark_mem[i] = 1'b0;
      tbl_phase = (count == '0) ? chtb_pkg::PH_READY : chtb_pkg::PH_SYMBOLS;
    endfunction

    function void assign_codes(chtb_pkg::hdr_t count);
      int             left;
      int             n;
      int             i;
      int             sum;
      chtb_pkg::hdr_t s;
      left = int'(sym_total) - int'(next_idx);
      n    = int'(count);
      if (n > left) begin
        n          = left;
        err_sticky = 1'b1;
      end
      if (n > 0 && cur_len > MAX_LEN) begin
        err_sticky = 1'b1;
        next_idx   = next_idx + chtb_pkg::cnt_t'(n);
      end else begin
        for (i = 0; i < n; i++) begin
          s           = order_mem[next_idx[chtb_pkg::HDR_W-1:0]];
          code_mem[s] = chtb_pkg::code_t'(run_code & ((1 << cur_len) - 1));
          len_mem[s]  = cur_len;
          mark_mem[s] = 1'b1;
          run_code    = run_code + 1'b1;
          next_idx    = next_idx + 1'b1;
        end
      end
      run_code = run_code << 1;
      if (cur_len <= MAX_LEN) cur_len = cur_len + 1'b1;
      sum = int'(covered) + int'(count);
      covered = (sum > int'(chtb_pkg::CNT_SAT)) ? chtb_pkg::CNT_SAT
                                                : chtb_pkg::cnt_t'(sum);
      if (covered >= sym_total) tbl_phase = chtb_pkg::PH_READY;
    endfunction

    function void note_transfer(logic op, chtb_pkg::hdr_t word, chtb_pkg::hdr_t sym);
      answer_t due;
      if (op == chtb_pkg::OP_HEADER) begin
        case (tbl_phase)
          chtb_pkg::PH_SYMBOLS: begin
            order_mem[sym_seen[chtb_pkg::HDR_W-1:0]] = word;
            sym_seen = sym_seen + 1'b1;
            if (sym_seen >= sym_total) tbl_phase = chtb_pkg::PH_LENGTHS;
          end
          chtb_pkg::PH_LENGTHS: assign_codes(word);
          default: open_table(word);
        endcase
      end else begin
        due = '0;
        if (mark_mem[sym]) begin
          due.found = 1'b1;
          due.code  = code_mem[sym];
          due.len   = len_mem[sym];
        end
        due.ready = (tbl_phase == chtb_pkg::PH_READY);
        due.err   = err_sticky;
        answers_due.push_back(due);
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      bit      bad;
      if (answers_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: found=%0b code=%h len=%0d ready=%0b err=%0b",
                   got.found, got.code, got.len, got.ready, got.err);
        return;
      end
      want = answers_due.pop_front();
      bad  = (got.found !== want.found) || (got.code !== want.code) ||
             (got.len !== want.len) || (got.ready !== want.ready) ||
             (got.err !== want.err);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result differs: expected found=%0b code=%h len=%0d ready=%0b err=%0b",
                   want.found, want.code, want.len, want.ready, want.err);
          $display("                actual   found=%0b code=%h len=%0d ready=%0b err=%0b",
                   got.found, got.code, got.len, got.ready, got.err);
        end
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        opcode_i       = chtb_pkg::OP_HEADER;
  logic [8:0]  header_word_i  = '0;
  logic [8:0]  query_symbol_i = '0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        found_o;
  logic [15:0] code_value_o;
  logic [4:0]  code_length_o;
  logic        table_ready_o;
  logic        error_flag_o;

  code_table_tracker tracker = new();

  chtb_pkg::hdr_t table_syms [$];
  int             items_sent = 0;
  bit             tx_calm    = 1'b0;
  bit             rx_calm    = 1'b0;
  int             rx_wait    = 0;

  canonical_huffman_table_builder_unit #(
    .SYMBOL_BITS  (chtb_pkg::HDR_W),
    .MAX_CODE_LEN (MAX_LEN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .header_word_i  (header_word_i),
    .query_symbol_i (query_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .code_value_o   (code_value_o),
    .code_length_o  (code_length_o),
    .table_ready_o  (table_ready_o),
    .error_flag_o   (error_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 5000000);
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait     <= rx_wait - 1;
    end else begin
      out_ready_i <= 1'b1;
      rx_wait     <= pick_gap(rx_calm);
    end
    if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
  end

  // transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_ready_i)
        tracker.check_answer(answer_t'({found_o, code_value_o, code_length_o,
                                        table_ready_o, error_flag_o}));
      if (in_valid_i && in_ready_o === 1'b1)
        tracker.note_transfer(opcode_i, header_word_i, query_symbol_i);
    end
  end

  task automatic send_item(logic op, chtb_pkg::hdr_t word, chtb_pkg::hdr_t sym);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    header_word_i  <= word;
    query_symbol_i <= sym;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_header(chtb_pkg::hdr_t word);
    send_item(chtb_pkg::OP_HEADER, word, chtb_pkg::hdr_t'($urandom));
  endtask

  task automatic send_query(chtb_pkg::hdr_t sym);
    send_item(chtb_pkg::OP_QUERY, chtb_pkg::hdr_t'($urandom), sym);
  endtask

  function automatic chtb_pkg::hdr_t pick_symbol();
    if (table_syms.size() != 0 && $urandom_range(0, 9) < 7)
      return table_syms[$urandom_range(0, table_syms.size() - 1)];
    return chtb_pkg::hdr_t'($urandom_range(0, 511));
  endfunction

  task automatic maybe_query();
    if ($urandom_range(0, 3) == 0) send_query(pick_symbol());
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic run_table(int total, shape_e shape);
    int             i;
    int             left;
    int             avail;
    int             len;
    int             hi;
    int             c;
    int             deep_zeros;
    int             base;
    bit             pooled;
    chtb_pkg::hdr_t s;
    table_syms.delete();
    send_header(chtb_pkg::hdr_t'(total));
    pooled = $urandom_range(0, 1);
    base   = $urandom_range(0, 496);
    for (i = 0; i < total; i++) begin
      maybe_query();
      s = pooled ? chtb_pkg::hdr_t'(base + $urandom_range(0, 15))
                 : chtb_pkg::hdr_t'($urandom_range(0, 511));
      table_syms.push_back(s);
      send_header(s);
    end
    left       = total;
    avail      = 2;
    len        = 1;
    deep_zeros = $urandom_range(12, 18);
    while (left > 0) begin
      maybe_query();
      case (shape)
        TBL_KRAFT: begin
          hi = (avail < left) ? avail : left;
          if (hi == avail && left > avail) hi = avail - 1;
          c = (len >= MAX_LEN) ? left : $urandom_range(0, hi);
        end
        TBL_LOOSE: c = $urandom_range(0, left);
        TBL_OVERRUN: begin
          if ($urandom_range(0, 2) == 0 || len >= 6) c = $urandom_range(left + 1, 511);
          else c = $urandom_range(0, left);
        end
        default: c = (len <= deep_zeros) ? 0 : left;
      endcase
      send_header(chtb_pkg::hdr_t'(c));
      if (c >= avail) avail = 0;
      else avail = (avail - c > 512) ? 1024 : 2 * (avail - c);
      left = (c >= left) ? 0 : left - c;
      len++;
    end
    repeat ($urandom_range(2, 6)) send_query(pick_symbol());
  endtask

  initial begin
    int seq_pick;
    int total;
    bit big_done;
    big_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty lookup, zero count, repeated symbol, overflowing codes
    send_query(9'd0);
    send_header(9'd0);
    send_query(9'd511);
    send_header(9'd3);
    send_header(9'd5);
    send_header(9'd511);
    send_header(9'd5);
    send_header(9'd1);
    send_header(9'd2);
    send_query(9'd5);
    send_query(9'd511);
    send_header(9'd3);
    send_header(9'd9);
    send_header(9'd10);
    send_header(9'd11);
    send_header(9'd3);
    send_query(9'd11);
    // count overrun last, the error flag stays set from here on
    send_header(9'd2);
    send_header(9'd0);
    send_header(9'd1);
    send_header(9'd511);
    send_query(9'd1);
    hold_until_drained();

    while (items_sent < 1450) begin
      tx_calm  = ($urandom_range(0, 4) == 0);
      seq_pick = $urandom_range(0, 99);
      total    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      if (!big_done && items_sent > 500) begin
        big_done = 1'b1;
        run_table($urandom_range(300, 511), TBL_KRAFT);
      end else if (seq_pick < 50) begin
        run_table(total, TBL_KRAFT);
      end else if (seq_pick < 60) begin
        run_table(total, TBL_LOOSE);
      end else if (seq_pick < 70) begin
        run_table(total, TBL_OVERRUN);
      end else if (seq_pick < 80) begin
        run_table($urandom_range(1, 4), TBL_DEEP);
      end else if (seq_pick < 88) begin
        run_table(0, TBL_KRAFT);
      end else begin
        repeat ($urandom_range(3, 10)) send_query(chtb_pkg::hdr_t'($urandom_range(0, 511)));
      end
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
